// File: sv/dcp_pkg.sv
// Shared types, register codes and helper functions for the distance
// constraint projection unit. No dependencies.
`default_nettype none

package dcp_pkg;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_STRENGTH = 2'd0;
  localparam logic [1:0] REG_REST     = 2'd1;
  localparam logic [1:0] REG_ENABLE   = 2'd2;

  localparam logic [15:0] STRENGTH_RST = 16'd16384;
  localparam logic [30:0] REST_RST     = 31'd65536;
  localparam logic        ENABLE_RST   = 1'b1;

  localparam logic [32:0] DIST_MIN = 33'd65536;
  localparam logic [31:0] POS_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] POS_MIN  = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_FAULT = 2'd1,
    MODE_CALC  = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [15:0]        fac_a;
    logic [15:0]        fac_b;
    logic [16:0]        den;
    mode_e              mode;
  } ctx_t;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? 33'(-v) : 33'(v);
    return t[31:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [54:0] v);
    logic [31:0] r;
    if (v[54:31] == {24{v[54]}}) begin
      r = v[31:0];
    end else if (v[54]) begin
      r = POS_MIN;
    end else begin
      r = POS_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/dcp_front.sv
// Input stage: registers a request, forms the difference vector and
// classifies it (pass, fault, compute). Depends on dcp_pkg.
`default_nettype none

module dcp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic [15:0]        a_inv_mass_i,
  input  logic [15:0]        b_inv_mass_i,
  input  logic               a_active_i,
  input  logic               b_active_i,
  input  logic               cen_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output dcp_pkg::ctx_t      push_ctx_o
);

  logic          f_valid_q, f_valid_d;
  dcp_pkg::ctx_t ctx_q, ctx_d;
  logic          accept;
  logic [16:0]   sum;

  assign in_ready_o   = !f_valid_q || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = f_valid_q;
  assign push_ctx_o   = ctx_q;

  always_comb begin
    sum      = {1'b0, a_inv_mass_i} + {1'b0, b_inv_mass_i};
    ctx_d.ax = a_x_i;
    ctx_d.ay = a_y_i;
    ctx_d.bx = b_x_i;
    ctx_d.by = b_y_i;
    ctx_d.dx = 33'(b_x_i) - 33'(a_x_i);
    ctx_d.dy = 33'(b_y_i) - 33'(a_y_i);
    if (a_active_i && b_active_i) begin
      ctx_d.fac_a = a_inv_mass_i;
      ctx_d.fac_b = b_inv_mass_i;
      ctx_d.den   = sum;
    end else if (a_active_i) begin
      ctx_d.fac_a = 16'd1;
      ctx_d.fac_b = 16'd0;
      ctx_d.den   = 17'd1;
    end else begin
      ctx_d.fac_a = 16'd0;
      ctx_d.fac_b = 16'd1;
      ctx_d.den   = 17'd1;
    end
    if (!cen_i || (!a_active_i && !b_active_i)) begin
      ctx_d.mode = dcp_pkg::MODE_PASS;
    end else if (a_active_i && b_active_i && (sum == 17'd0)) begin
      ctx_d.mode = dcp_pkg::MODE_FAULT;
    end else begin
      ctx_d.mode = dcp_pkg::MODE_CALC;
    end
  end

  assign f_valid_d = accept || (f_valid_q && !push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctx_q <= ctx_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/dcp_queue.sv
// Short request queue between the front and back parts.
// Depends on dcp_pkg.
`default_nettype none

module dcp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dcp_pkg::ctx_t push_ctx_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dcp_pkg::ctx_t pop_ctx_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dcp_pkg::ctx_t   mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_ctx_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_ctx_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/dcp_back.sv
// Back pipeline: squares, pipelined square root, stiffness divide, mass
// split divide, displacement multiply and saturating update. Depends on dcp_pkg.
`default_nettype none

module dcp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  dcp_pkg::ctx_t      pop_ctx_i,
  input  logic [15:0]        strength_i,
  input  logic [30:0]        rest_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_a_x_o,
  output logic signed [31:0] new_a_y_o,
  output logic signed [31:0] new_b_x_o,
  output logic signed [31:0] new_b_y_o,
  output logic               mass_fault_o
);

  localparam int unsigned SQ_N = 33;
  localparam int unsigned DV_N = 46;

  logic en;

  // squares
  logic          a_v_q;
  dcp_pkg::ctx_t a_ctx_q;
  logic [63:0]   a_sx_q, a_sy_q;
  logic [31:0]   a_dxm, a_dym;

  // root
  logic          r_v_q     [SQ_N+1];
  dcp_pkg::ctx_t r_ctx_q   [SQ_N+1];
  logic [65:0]   r_s_q     [SQ_N+1];
  logic          r_small_q [SQ_N+1];
  logic [35:0]   r_rem_q   [SQ_N+1];
  logic [32:0]   r_root_q  [SQ_N+1];
  logic [64:0]   s_sum;

  // stiffness divide
  logic          d_v_q    [DV_N+1];
  dcp_pkg::ctx_t d_ctx_q  [DV_N+1];
  logic [49:0]   d_num_q  [DV_N+1];
  logic          d_neg_q  [DV_N+1];
  logic [32:0]   d_dist_q [DV_N+1];
  logic [32:0]   d_rem_q  [DV_N+1];
  logic [45:0]   d_q_q    [DV_N+1];
  logic [32:0]   c_dist;
  logic signed [34:0] c_diff, c_ndiff;
  logic [33:0]   c_dmag;
  logic [49:0]   c_num;

  // mass split divide
  logic          g_v_q   [DV_N+1];
  dcp_pkg::ctx_t g_ctx_q [DV_N+1];
  logic          g_neg_q [DV_N+1];
  logic [61:0]   g_pa_q  [DV_N+1];
  logic [61:0]   g_pb_q  [DV_N+1];
  logic [16:0]   g_ra_q  [DV_N+1];
  logic [16:0]   g_rb_q  [DV_N+1];
  logic [45:0]   g_qa_q  [DV_N+1];
  logic [45:0]   g_qb_q  [DV_N+1];
  logic [61:0]   e_pa, e_pb;

  // displacement: 0 a.x, 1 a.y, 2 b.x, 3 b.y
  logic          m1_v_q, m2_v_q;
  dcp_pkg::ctx_t m1_ctx_q, m2_ctx_q;
  logic          m1_neg_q [4];
  logic [54:0]   m1_lo_q  [4];
  logic [54:0]   m1_hi_q  [4];
  logic [31:0]   m1_dm    [4];
  logic [45:0]   m1_g     [4];
  logic [54:0]   m1_lo    [4];
  logic [54:0]   m1_hi    [4];
  logic [78:0]   m2_sum   [4];
  logic [53:0]   m2_p     [4];
  logic signed [53:0] m2_disp [4];
  logic signed [53:0] m2_disp_q [4];

  // output
  logic               out_valid_q;
  logic signed [31:0] o_ax_q, o_ay_q, o_bx_q, o_by_q;
  logic               o_fault_q;
  logic [54:0]        o_sum [4];
  logic [31:0]        o_sat [4];
  logic               o_calc;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;

  // ---------------- squares
  assign a_dxm = dcp_pkg::mag33(pop_ctx_i.dx);
  assign a_dym = dcp_pkg::mag33(pop_ctx_i.dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctx_q <= pop_ctx_i;
      a_sx_q  <= a_dxm * a_dxm;
      a_sy_q  <= a_dym * a_dym;
    end
  end

  // ---------------- sum of squares
  assign s_sum = {1'b0, a_sx_q} + {1'b0, a_sy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q[0] <= 1'b0;
    end else if (en) begin
      r_v_q[0] <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_ctx_q[0]   <= a_ctx_q;
      r_s_q[0]     <= {1'b0, s_sum};
      r_small_q[0] <= s_sum[64:32] == 33'd0;
      r_rem_q[0]   <= '0;
      r_root_q[0]  <= '0;
    end
  end

  // ---------------- square root, one result bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam int unsigned PB = 2 * (SQ_N - 1 - k);
    logic [35:0] remx, trial;
    logic        ge;

    assign remx  = {r_rem_q[k][33:0], r_s_q[k][PB+1:PB]};
    assign trial = {1'b0, r_root_q[k], 2'b01};
    assign ge    = remx >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_v_q[k+1] <= 1'b0;
      end else if (en) begin
        r_v_q[k+1] <= r_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_ctx_q[k+1]   <= r_ctx_q[k];
        r_s_q[k+1]     <= r_s_q[k];
        r_small_q[k+1] <= r_small_q[k];
        r_rem_q[k+1]   <= ge ? remx - trial : remx;
        r_root_q[k+1]  <= {r_root_q[k][31:0], ge};
      end
    end
  end

  // ---------------- stiffness numerator
  always_comb begin
    c_dist  = r_small_q[SQ_N] ? dcp_pkg::DIST_MIN : r_root_q[SQ_N];
    c_diff  = signed'({2'b00, c_dist}) - signed'({4'b0000, rest_i});
    c_ndiff = -c_diff;
    c_dmag  = c_diff[34] ? c_ndiff[33:0] : c_diff[33:0];
    c_num   = {34'd0, strength_i} * {16'd0, c_dmag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q[0] <= 1'b0;
    end else if (en) begin
      d_v_q[0] <= r_v_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ctx_q[0]  <= r_ctx_q[SQ_N];
      d_num_q[0]  <= c_num;
      d_neg_q[0]  <= c_diff[34];
      d_dist_q[0] <= c_dist;
      d_rem_q[0]  <= {17'd0, c_num[49:34]};
      d_q_q[0]    <= '0;
    end
  end

  // ---------------- (num << 12) / dist, restoring
  for (genvar j = 0; j < DV_N; j++) begin : g_div1
    logic        dbit, ge;
    logic [33:0] remx, dv;

    if (j <= 33) begin : g_bit
      assign dbit = d_num_q[j][33-j];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign remx = {d_rem_q[j], dbit};
    assign dv   = {1'b0, d_dist_q[j]};
    assign ge   = remx >= dv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[j+1] <= 1'b0;
      end else if (en) begin
        d_v_q[j+1] <= d_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_ctx_q[j+1]  <= d_ctx_q[j];
        d_num_q[j+1]  <= d_num_q[j];
        d_neg_q[j+1]  <= d_neg_q[j];
        d_dist_q[j+1] <= d_dist_q[j];
        d_rem_q[j+1]  <= ge ? 33'(remx - dv) : remx[32:0];
        d_q_q[j+1]    <= {d_q_q[j][44:0], ge};
      end
    end
  end

  // ---------------- mass split products
  assign e_pa = d_q_q[DV_N] * d_ctx_q[DV_N].fac_a;
  assign e_pb = d_q_q[DV_N] * d_ctx_q[DV_N].fac_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q[0] <= 1'b0;
    end else if (en) begin
      g_v_q[0] <= d_v_q[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_ctx_q[0] <= d_ctx_q[DV_N];
      g_neg_q[0] <= d_neg_q[DV_N];
      g_pa_q[0]  <= e_pa;
      g_pb_q[0]  <= e_pb;
      g_ra_q[0]  <= {1'b0, e_pa[61:46]};
      g_rb_q[0]  <= {1'b0, e_pb[61:46]};
      g_qa_q[0]  <= '0;
      g_qb_q[0]  <= '0;
    end
  end

  // ---------------- product / den (inverse-mass sum, or 1 with one end active), two lanes
  for (genvar j = 0; j < DV_N; j++) begin : g_div2
    logic [17:0] rxa, rxb, dv;
    logic        gea, geb;

    assign dv  = {1'b0, g_ctx_q[j].den};
    assign rxa = {g_ra_q[j], g_pa_q[j][DV_N-1-j]};
    assign rxb = {g_rb_q[j], g_pb_q[j][DV_N-1-j]};
    assign gea = rxa >= dv;
    assign geb = rxb >= dv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        g_v_q[j+1] <= 1'b0;
      end else if (en) begin
        g_v_q[j+1] <= g_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        g_ctx_q[j+1] <= g_ctx_q[j];
        g_neg_q[j+1] <= g_neg_q[j];
        g_pa_q[j+1]  <= g_pa_q[j];
        g_pb_q[j+1]  <= g_pb_q[j];
        g_ra_q[j+1]  <= gea ? 17'(rxa - dv) : rxa[16:0];
        g_rb_q[j+1]  <= geb ? 17'(rxb - dv) : rxb[16:0];
        g_qa_q[j+1]  <= {g_qa_q[j][44:0], gea};
        g_qb_q[j+1]  <= {g_qb_q[j][44:0], geb};
      end
    end
  end

  // ---------------- displacement partial products
  always_comb begin
    m1_dm[0] = dcp_pkg::mag33(g_ctx_q[DV_N].dx);
    m1_dm[1] = dcp_pkg::mag33(g_ctx_q[DV_N].dy);
    m1_dm[2] = m1_dm[0];
    m1_dm[3] = m1_dm[1];
    m1_g[0]  = g_qa_q[DV_N];
    m1_g[1]  = g_qa_q[DV_N];
    m1_g[2]  = g_qb_q[DV_N];
    m1_g[3]  = g_qb_q[DV_N];
    for (int i = 0; i < 4; i++) begin
      m1_lo[i] = m1_dm[i] * m1_g[i][22:0];
      m1_hi[i] = m1_dm[i] * m1_g[i][45:23];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= g_v_q[DV_N];
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_ctx_q    <= g_ctx_q[DV_N];
      m1_neg_q[0] <= g_ctx_q[DV_N].dx[32] ^ g_neg_q[DV_N];
      m1_neg_q[1] <= g_ctx_q[DV_N].dy[32] ^ g_neg_q[DV_N];
      m1_neg_q[2] <= g_ctx_q[DV_N].dx[32] ^ g_neg_q[DV_N];
      m1_neg_q[3] <= g_ctx_q[DV_N].dy[32] ^ g_neg_q[DV_N];
      m1_lo_q     <= m1_lo;
      m1_hi_q     <= m1_hi;
    end
  end

  // ---------------- combine, drop 26 fraction bits, apply sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m2_sum[i]  = {1'b0, m1_hi_q[i], 23'd0} + {24'd0, m1_lo_q[i]};
      m2_p[i]    = {1'b0, m2_sum[i][78:26]};
      m2_disp[i] = m1_neg_q[i] ? -signed'(m2_p[i]) : signed'(m2_p[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_ctx_q  <= m1_ctx_q;
      m2_disp_q <= m2_disp;
    end
  end

  // ---------------- update and saturate
  always_comb begin
    o_sum[0] = {{23{m2_ctx_q.ax[31]}}, m2_ctx_q.ax} + {m2_disp_q[0][53], m2_disp_q[0]};
    o_sum[1] = {{23{m2_ctx_q.ay[31]}}, m2_ctx_q.ay} + {m2_disp_q[1][53], m2_disp_q[1]};
    o_sum[2] = {{23{m2_ctx_q.bx[31]}}, m2_ctx_q.bx} - {m2_disp_q[2][53], m2_disp_q[2]};
    o_sum[3] = {{23{m2_ctx_q.by[31]}}, m2_ctx_q.by} - {m2_disp_q[3][53], m2_disp_q[3]};
    for (int i = 0; i < 4; i++) begin
      o_sat[i] = dcp_pkg::sat32(o_sum[i]);
    end
    o_calc = m2_ctx_q.mode == dcp_pkg::MODE_CALC;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_ax_q    <= o_calc ? o_sat[0] : m2_ctx_q.ax;
      o_ay_q    <= o_calc ? o_sat[1] : m2_ctx_q.ay;
      o_bx_q    <= o_calc ? o_sat[2] : m2_ctx_q.bx;
      o_by_q    <= o_calc ? o_sat[3] : m2_ctx_q.by;
      o_fault_q <= m2_ctx_q.mode == dcp_pkg::MODE_FAULT;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_a_x_o    = o_ax_q;
  assign new_a_y_o    = o_ay_q;
  assign new_b_x_o    = o_bx_q;
  assign new_b_y_o    = o_by_q;
  assign mass_fault_o = o_fault_q;

endmodule

`default_nettype wire

// File: sv/distance_constraint_projection_unit.sv
// The back part holds a 33-stage square root and two 46-stage restoring
// dividers. Throughput: one request per cycle; the whole back pipeline stalls
// only while a result waits at the output. Reset clears all valid state and
// loads the register defaults; there is no clearing pass.
// Top level: APB registers, front, queue and back. Depends on dcp_pkg.
`default_nettype none

module distance_constraint_projection_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           a_x_i,
  input  logic signed [31:0]           a_y_i,
  input  logic signed [31:0]           b_x_i,
  input  logic signed [31:0]           b_y_i,
  input  logic [15:0]                  a_inv_mass_i,
  input  logic [15:0]                  b_inv_mass_i,
  input  logic                         a_active_i,
  input  logic                         b_active_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           new_a_x_o,
  output logic signed [31:0]           new_a_y_o,
  output logic signed [31:0]           new_b_x_o,
  output logic signed [31:0]           new_b_y_o,
  output logic                         mass_fault_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [15:0]   strength_q;
  logic [30:0]   rest_q;
  logic          enable_q;
  logic          wr;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  dcp_pkg::ctx_t push_ctx, pop_ctx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= dcp_pkg::STRENGTH_RST;
      rest_q     <= dcp_pkg::REST_RST;
      enable_q   <= dcp_pkg::ENABLE_RST;
    end else if (wr) begin
      case (paddr[3:2])
        dcp_pkg::REG_STRENGTH: strength_q <= pwdata[15:0];
        dcp_pkg::REG_REST:     rest_q     <= pwdata[30:0];
        dcp_pkg::REG_ENABLE:   enable_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dcp_pkg::REG_STRENGTH: prdata = {16'd0, strength_q};
      dcp_pkg::REG_REST:     prdata = {1'b0, rest_q};
      dcp_pkg::REG_ENABLE:   prdata = {31'd0, enable_q};
      default:               prdata = '0;
    endcase
  end

  dcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .a_inv_mass_i (a_inv_mass_i),
    .b_inv_mass_i (b_inv_mass_i),
    .a_active_i   (a_active_i),
    .b_active_i   (b_active_i),
    .cen_i        (enable_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ctx_o   (push_ctx)
  );

  dcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_ctx_i   (push_ctx),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_ctx_o    (pop_ctx)
  );

  dcp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_ctx_i    (pop_ctx),
    .strength_i   (strength_q),
    .rest_i       (rest_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .new_a_x_o    (new_a_x_o),
    .new_a_y_o    (new_a_y_o),
    .new_b_x_o    (new_b_x_o),
    .new_b_y_o    (new_b_y_o),
    .mass_fault_o (mass_fault_o)
  );

endmodule

`default_nettype wire

// File: sv/dcp_checker.sv
// Port-level checks for the distance constraint projection unit, bound to
// the top level. Depends on dcp_pkg.
`default_nettype none

module dcp_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_o,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic signed [31:0]         new_a_x_o,
  input  logic signed [31:0]         new_a_y_o,
  input  logic signed [31:0]         new_b_x_o,
  input  logic signed [31:0]         new_b_y_o,
  input  logic                       mass_fault_o,
  input  logic                       psel,
  input  logic                       pwrite,
  input  logic [dcp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                prdata,
  input  logic                       pready
);

  logic [15:0] outst_q, outst_d;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign outst_d = outst_q + 16'(in_acc) - 16'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_a_x_o) &&
    $stable(new_a_y_o) && $stable(new_b_x_o) && $stable(new_b_y_o) &&
    $stable(mass_fault_o))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outst_q != 16'd0)
    else $error("result without outstanding request");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  a_enable_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && (paddr[3:2] == dcp_pkg::REG_ENABLE) |-> prdata[31:1] == 31'd0)
    else $error("enable readback too wide");

  a_strength_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && (paddr[3:2] == dcp_pkg::REG_STRENGTH) |-> prdata[31:16] == 16'd0)
    else $error("strength readback too wide");

endmodule

bind distance_constraint_projection_unit dcp_checker u_dcp_checker (.*);

`default_nettype wire
